[hdl/serial_sync_length_deframer_core_macros.svh]
// Assertion macros shared by the deframer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SERIAL_SYNC_LENGTH_DEFRAMER_CORE_MACROS_SVH
`define SERIAL_SYNC_LENGTH_DEFRAMER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSLD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ssld: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ssld: next-cycle check failed");

`endif

[hdl/ssld_pkg.sv]
// Types and constants of the sync-word, length-prefixed serial deframer.
// Depends on nothing; imported by serial_sync_length_deframer_core.
`default_nettype none

package ssld_pkg;

    // Frame parser phases.
    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_LEN_LO  = 2'd1,
        PH_LEN_HI  = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    // Kinds of result transaction.
    typedef enum logic {
        EV_PAYLOAD = 1'b0,
        EV_BAD_LEN = 1'b1
    } t_event_kind;

    localparam logic [15:0] MAX_FRAME_LEN_RST = 16'd1024;
    localparam logic [1:0]  SYNC_LAST_IDX     = 2'd3;

    // Sync word DE CA FB AD, first byte at index zero.
    function automatic logic [7:0] sync_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'hDE;
            2'd1: b = 8'hCA;
            2'd2: b = 8'hFB;
            2'd3: b = 8'hAD;
            default: b = 8'hDE;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[hdl/serial_sync_length_deframer_core.sv]
// Top level of the sync-word, length-prefixed serial deframer.
// Depends on ssld_pkg and serial_sync_length_deframer_core_macros.svh.
//
// This block accepts one received serial byte per transaction, hunts for the
// sync word DE CA FB AD, reads a two-byte length with the low byte first and
// then hands on each payload byte with its offset in the frame and a flag on
// the last one. A length of zero, or one above max_frame_len, produces a
// single rejection transaction carrying that length, after which the block
// hunts for the sync word again. On a sync mismatch the hunt restarts at the
// first sync byte without comparing the mismatching byte once more. The
// block takes one byte every clock cycle while o_stall is low. An accepted
// byte is held in the input register, and its result, if any, is loaded
// into the result register once that register is empty or being drained.
// The whole per-byte state update sits between these two registers. Stall
// on the result side propagates back to o_stall in the same cycle, so no
// byte is lost or repeated. The maximum length register resets to 1024 and
// should be written only while the block is idle; its write channel is
// always ready.
`default_nettype none
`include "serial_sync_length_deframer_core_macros.svh"

module serial_sync_length_deframer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input byte channel.
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    // Result channel.
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_event_kind,
    output logic [7:0]       o_payload_byte,
    output logic [15:0]      o_byte_offset,
    output logic             o_last_of_frame,
    output logic [15:0]      o_bad_length,
    // Configuration channel: maximum frame length.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    import ssld_pkg::*;

    // Input register stage.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Parser state.
    t_phase      r_phase, n_phase;
    logic [1:0]  r_sync_index, n_sync_index;
    logic [15:0] r_frame_len, n_frame_len;
    logic [15:0] r_payload_count, n_payload_count;
    logic [15:0] r_max_frame_len;

    // Result register stage.
    logic        r_out_valid;
    t_event_kind r_out_kind;
    logic [7:0]  r_out_byte;
    logic [15:0] r_out_offset;
    logic        r_out_last;
    logic [15:0] r_out_bad_len;

    // Result of the byte held in the input register.
    logic        res_valid;
    t_event_kind res_kind;
    logic [7:0]  res_byte;
    logic [15:0] res_offset;
    logic        res_last;
    logic [15:0] res_bad_len;

    logic        s2_take;
    logic        s2_fire;
    logic        in_accept;
    logic [15:0] len_full;
    logic [15:0] count_inc;

    // The result register can load whenever it is empty or being drained.
    // The input register can load whenever it is empty or moving onwards.
    assign s2_take   = !r_out_valid || !i_stall;
    assign s2_fire   = r_in_valid && s2_take;
    assign o_stall   = r_in_valid && !s2_take;
    assign in_accept = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    // Full length once the high byte arrives, and the running payload count.
    assign len_full  = {r_in_byte, r_frame_len[7:0]};
    assign count_inc = r_payload_count + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame_len <= MAX_FRAME_LEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_frame_len <= i_cfg_data;
        end
    end

    // Parser state register; it moves only when a byte leaves the input
    // register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HUNT;
            r_sync_index    <= 2'd0;
            r_frame_len     <= 16'd0;
            r_payload_count <= 16'd0;
        end else if (s2_fire) begin
            r_phase         <= n_phase;
            r_sync_index    <= n_sync_index;
            r_frame_len     <= n_frame_len;
            r_payload_count <= n_payload_count;
        end
    end

    // Next state and result for the byte in the input register.
    always_comb begin
        n_phase         = r_phase;
        n_sync_index    = r_sync_index;
        n_frame_len     = r_frame_len;
        n_payload_count = r_payload_count;
        res_valid       = 1'b0;
        res_kind        = EV_PAYLOAD;
        res_byte        = 8'd0;
        res_offset      = 16'd0;
        res_last        = 1'b0;
        res_bad_len     = 16'd0;
        unique case (r_phase)
            PH_HUNT: begin
                if (r_in_byte == sync_byte(r_sync_index)) begin
                    if (r_sync_index == SYNC_LAST_IDX) begin
                        n_sync_index = 2'd0;
                        n_phase      = PH_LEN_LO;
                    end else begin
                        n_sync_index = r_sync_index + 2'd1;
                    end
                end else begin
                    n_sync_index = 2'd0;
                end
            end
            PH_LEN_LO: begin
                n_frame_len = {8'd0, r_in_byte};
                n_phase     = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                if ((len_full != 16'd0) && (len_full <= r_max_frame_len)) begin
                    n_frame_len     = len_full;
                    n_payload_count = 16'd0;
                    n_phase         = PH_PAYLOAD;
                end else begin
                    // Rejected length: report it and go back to hunting.
                    res_valid       = 1'b1;
                    res_kind        = EV_BAD_LEN;
                    res_bad_len     = len_full;
                    n_frame_len     = 16'd0;
                    n_payload_count = 16'd0;
                    n_sync_index    = 2'd0;
                    n_phase         = PH_HUNT;
                end
            end
            PH_PAYLOAD: begin
                res_valid       = 1'b1;
                res_kind        = EV_PAYLOAD;
                res_byte        = r_in_byte;
                res_offset      = r_payload_count;
                res_last        = (count_inc == r_frame_len);
                n_payload_count = count_inc;
                if (count_inc == r_frame_len) begin
                    n_frame_len     = 16'd0;
                    n_payload_count = 16'd0;
                    n_sync_index    = 2'd0;
                    n_phase         = PH_HUNT;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_take) begin
            r_out_valid <= r_in_valid && res_valid;
        end
        if (s2_fire && res_valid) begin
            r_out_kind    <= res_kind;
            r_out_byte    <= res_byte;
            r_out_offset  <= res_offset;
            r_out_last    <= res_last;
            r_out_bad_len <= res_bad_len;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_event_kind    = r_out_kind;
    assign o_payload_byte  = r_out_byte;
    assign o_byte_offset   = r_out_offset;
    assign o_last_of_frame = r_out_last;
    assign o_bad_length    = r_out_bad_len;

    // Stall is only ever raised against a byte already held.
    `SSLD_ASSERT_NOW(a_stall_needs_byte, i_clk, i_rst_n, o_stall, r_in_valid)
    // Sync progress exists only while hunting.
    `SSLD_ASSERT_NOW(a_sync_only_hunting, i_clk, i_rst_n, r_sync_index != 2'd0,
        r_phase == PH_HUNT)
    // In payload the frame is non-empty and not yet complete.
    `SSLD_ASSERT_NOW(a_payload_bounds, i_clk, i_rst_n, r_phase == PH_PAYLOAD,
        (r_frame_len != 16'd0) && (r_payload_count < r_frame_len))
    // A rejection always sends the parser back to hunting.
    `SSLD_ASSERT_NEXT(a_reject_resyncs, i_clk, i_rst_n,
        s2_fire && res_valid && (res_kind == EV_BAD_LEN), r_phase == PH_HUNT)
    // A pending last byte means its frame is already closed.
    `SSLD_ASSERT_NOW(a_last_closes_frame, i_clk, i_rst_n,
        r_out_valid && r_out_last && (r_out_kind == EV_PAYLOAD),
        (r_phase == PH_HUNT) && (r_sync_index == 2'd0) && (r_frame_len == 16'd0))

endmodule

`default_nettype wire
